/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// property checked on every rising edge, reset included
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* src/nsv_pkg.sv */
// types, codes and helpers for the nmea sentence validator
package nsv_pkg;

    localparam int COUNT_WIDTH = 10;
    localparam int LEN_W       = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CMP_W       = ((COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W) + 1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = {COUNT_WIDTH{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRICT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'd1;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd82;

    // phase codes
    localparam logic [2:0] PH_DOLLAR    = 3'd0;
    localparam logic [2:0] PH_BODY      = 3'd1;
    localparam logic [2:0] PH_HIGH      = 3'd2;
    localparam logic [2:0] PH_LOW       = 3'd3;
    localparam logic [2:0] PH_TAIL      = 3'd4;
    localparam logic [2:0] PH_TAIL_DONE = 3'd5;
    localparam logic [2:0] PH_TAIL_BAD  = 3'd6;
    localparam logic [2:0] PH_NOSTAR    = 3'd7;

    // error codes
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_LONG     = 3'd1;
    localparam logic [2:0] ERR_DOLLAR   = 3'd2;
    localparam logic [2:0] ERR_HIGH     = 3'd3;
    localparam logic [2:0] ERR_LOW      = 3'd4;
    localparam logic [2:0] ERR_MISMATCH = 3'd5;
    localparam logic [2:0] ERR_NOSUM    = 3'd6;
    localparam logic [2:0] ERR_ENDING   = 3'd7;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [4:0] HEX_NONE  = 5'd16;

    typedef struct packed {
        logic [2:0]             phase;
        logic [7:0]             run_xor;
        logic [3:0]             high_nib;
        logic [COUNT_WIDTH-1:0] count;
        logic [2:0]             err;
        logic                   cr_seen;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        phase:    PH_DOLLAR,
        run_xor:  8'd0,
        high_nib: 4'd0,
        count:    '0,
        err:      ERR_OK,
        cr_seen:  1'b0
    };

    typedef struct packed {
        logic [7:0] xor_val;
        logic [2:0] err;
        logic       ok;
    } t_verdict;

    // hex digit value, or HEX_NONE when the byte is not a digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = HEX_NONE;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 5'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 5'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 5'(b - 8'h57);
        end
        return v;
    endfunction

endpackage

/* src/nmea_sentence_validator.sv */
// nmea sentence validator: byte input register, sentence state and verdict register
// a final byte goes through the byte input register; its verdict is then held in the verdict register
// throughput: one byte per cycle; only a final byte meeting an untaken verdict stalls
// the verdict register decouples the sides so bytes keep flowing while a word waits
// reset (synchronous, active low) clears sentence state, strict mode 1, max length 82
// no clearing pass: the block accepts bytes as soon as reset is released
module nmea_sentence_validator
    import nsv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] char_byte
    input  logic                 s_axis_tlast,   // last_char
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [0] sentence_ok, [3:1] error_code,
                                                 // [11:4] computed_xor, [15:12] zero
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    t_state           r_state;
    logic             r_strict;
    logic [LEN_W-1:0] r_max_len;

    t_state   n_state;
    t_verdict verdict;
    t_verdict out_verdict;
    logic     out_stall;
    logic     stall;
    logic     proc;
    logic     in_fire;

    assign stall         = r_in_valid && r_in_last && out_stall;
    assign proc          = r_in_valid && !stall;
    assign s_axis_tready = !stall;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict  <= 1'b1;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STRICT:  r_strict  <= i_cfg_data[0];
                REG_MAX_LEN: r_max_len <= i_cfg_data;
                default:     r_strict  <= r_strict;
            endcase
        end
    end

    nsv_step u_step (
        .i_state   (r_state),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_strict  (r_strict),
        .i_max_len (r_max_len),
        .o_next    (n_state),
        .o_verdict (verdict)
    );

    nsv_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (proc && r_in_last),
        .i_verdict (verdict),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_verdict (out_verdict),
        .o_stall   (out_stall)
    );

    assign m_axis_tdata = {4'd0, out_verdict};

endmodule

/* src/nsv_step.sv */
// per-byte state update and sentence verdict
module nsv_step
    import nsv_pkg::*;
(
    input  t_state         i_state,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    input  logic           i_strict,
    input  logic [LEN_W-1:0] i_max_len,
    output t_state         o_next,
    output t_verdict       o_verdict
);

    t_state     ns;
    logic [4:0] hv;
    logic [2:0] err;
    logic       too_long;

    always_comb begin
        hv = hex_value(i_byte);
        ns = i_state;
        ns.count = (i_state.count == COUNT_SAT) ? i_state.count
                                                : i_state.count + COUNT_WIDTH'(1);

        // once an error is latched only the count moves
        if (i_state.err == ERR_OK) begin
            unique case (i_state.phase)
                PH_DOLLAR: begin
                    if (i_byte == CH_DOLLAR) ns.phase = PH_BODY;
                    else ns.err = ERR_DOLLAR;
                end
                PH_BODY: begin
                    if (i_byte == CH_STAR) ns.phase = PH_HIGH;
                    else if (i_byte >= CH_SPACE && i_byte <= CH_TILDE)
                        ns.run_xor = i_state.run_xor ^ i_byte;
                    else ns.phase = PH_NOSTAR;
                end
                PH_HIGH: begin
                    if (hv[4]) begin
                        ns.err = ERR_HIGH;
                    end else begin
                        ns.high_nib = hv[3:0];
                        ns.phase    = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (hv[4]) ns.err = ERR_LOW;
                    else if ({i_state.high_nib, hv[3:0]} != i_state.run_xor)
                        ns.err = ERR_MISMATCH;
                    else ns.phase = PH_TAIL;
                end
                PH_TAIL: begin
                    if (i_byte == CH_LF) ns.phase = PH_TAIL_DONE;
                    else if (i_byte == CH_CR && !i_state.cr_seen) ns.cr_seen = 1'b1;
                    else ns.phase = PH_TAIL_BAD;
                end
                PH_TAIL_DONE: ns.phase = PH_TAIL_BAD;
                PH_TAIL_BAD:  ns.phase = PH_TAIL_BAD;
                PH_NOSTAR:    ns.phase = PH_NOSTAR;
                default:      ns.phase = i_state.phase;
            endcase
        end

        too_long = CMP_W'(ns.count) > (CMP_W'(i_max_len) + CMP_W'(3));

        if (too_long) begin
            err = ERR_LONG;
        end else if (ns.err != ERR_OK) begin
            err = ns.err;
        end else begin
            unique case (ns.phase) inside
                PH_BODY, PH_NOSTAR: err = i_strict ? ERR_NOSUM : ERR_OK;
                PH_HIGH:            err = ERR_HIGH;
                PH_LOW:             err = ERR_LOW;
                PH_TAIL:            err = (ns.cr_seen && i_strict) ? ERR_ENDING : ERR_OK;
                PH_TAIL_BAD:        err = i_strict ? ERR_ENDING : ERR_OK;
                default:            err = ERR_OK;
            endcase
        end

        o_verdict.ok      = (err == ERR_OK);
        o_verdict.err     = err;
        o_verdict.xor_val = ns.run_xor;
        o_next = i_last ? STATE_CLEAR : ns;
    end

endmodule

/* src/nsv_out_reg.sv */
// result register on the master side
module nsv_out_reg
    import nsv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_verdict i_verdict,
    input  logic     i_ready,
    output logic     o_valid,
    output t_verdict o_verdict,
    output logic     o_stall
);

    logic     r_valid;
    t_verdict r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict <= i_verdict;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;
    // a held word that is not taken blocks the next verdict
    assign o_stall   = r_valid && !i_ready;

endmodule

/* src/nsv_checker.sv */
// port-level checks for the nmea sentence validator, bound to the top level
`include "assert_macros.svh"

module nsv_checker
    import nsv_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a word not taken stays offered
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    // ok flag agrees with the error code
    `ASSERT_CLK(a_ok_code, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == ERR_OK)))
    // a missing dollar leaves the checksum at zero
    `ASSERT_CLK(a_dollar_xor, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[3:1] == ERR_DOLLAR |-> m_axis_tdata[11:4] == 8'd0)
    // no verdict right after reset
    `ASSERT_CLK_NR(a_rst_clear, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (.*);

/* tb/sv/tb_nmea_sentence_validator.sv */
// self-checking testbench for the nmea sentence validator
`timescale 1ns / 100ps

module tb_nmea_sentence_validator;
    import nsv_pkg::*;

    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        logic       ok;
        logic [2:0] code;
        logic [7:0] xsum;
    } t_tb_verdict;

    typedef struct {
        logic        typed;
        t_tb_verdict want;
    } t_verdict_plan;

    typedef struct {
        string      text;
        logic       strict_on;
        int         max_len;
        logic       typed;
        logic [2:0] code;
        logic [7:0] xsum;
    } t_sentence_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_STRICT;
    logic [LEN_W-1:0]     i_cfg_data = '0;

    nmea_sentence_validator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sentence checker state, mirrored on accepted words
    logic [2:0]             sent_stage = PH_DOLLAR;
    logic [7:0]             sent_xor   = 8'h00;
    logic [3:0]             sent_hi    = 4'h0;
    logic [COUNT_WIDTH-1:0] sent_len   = '0;
    logic [2:0]             sent_err   = ERR_OK;
    logic                   sent_cr    = 1'b0;
    logic                   cfg_strict = 1'b1;
    logic [LEN_W-1:0]       cfg_max_len = MAX_LEN_RESET;

    t_tb_verdict   verdicts_due[$];
    t_verdict_plan sentence_plan[$];
    logic [7:0]    line_buf[$];
    t_sentence_row script[$];

    int   fails = 0;
    int   stall_cycles = 0;
    int   burst_left = 0;
    logic pacing = 1'b1;
    logic cur_strict = 1'b1;
    int   cur_max = 82;

    logic [15:0] rdy_pat = 16'hFFFF;
    logic [3:0]  rdy_pos = 4'd0;

    // {is_digit, value}
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            return {1'b1, 4'(c - 8'h57)};
        end
        return 5'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + 8'(n);
        end
        return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + 8'(n);
    endfunction

    task automatic take_char(input logic [7:0] c, input logic fin);
        logic [4:0]    dig;
        t_tb_verdict   v;
        t_verdict_plan p;
        if (sent_len != COUNT_SAT) begin
            sent_len = sent_len + 1'b1;
        end
        if (sent_err == ERR_OK) begin
            case (sent_stage)
                PH_DOLLAR: begin
                    if (c == CH_DOLLAR) sent_stage = PH_BODY;
                    else sent_err = ERR_DOLLAR;
                end
                PH_BODY: begin
                    if (c == CH_STAR) begin
                        sent_stage = PH_HIGH;
                    end else if (c >= CH_SPACE && c <= CH_TILDE) begin
                        sent_xor = sent_xor ^ c;
                    end else begin
                        sent_stage = PH_NOSTAR;
                    end
                end
                PH_HIGH: begin
                    dig = nibble_of(c);
                    if (!dig[4]) begin
                        sent_err = ERR_HIGH;
                    end else begin
                        sent_hi = dig[3:0];
                        sent_stage = PH_LOW;
                    end
                end
                PH_LOW: begin
                    dig = nibble_of(c);
                    if (!dig[4]) sent_err = ERR_LOW;
                    else if ({sent_hi, dig[3:0]} != sent_xor) sent_err = ERR_MISMATCH;
                    else sent_stage = PH_TAIL;
                end
                PH_TAIL: begin
                    if (c == CH_LF) sent_stage = PH_TAIL_DONE;
                    else if (c == CH_CR && !sent_cr) sent_cr = 1'b1;
                    else sent_stage = PH_TAIL_BAD;
                end
                PH_TAIL_DONE: begin
                    sent_stage = PH_TAIL_BAD;
                end
                default: begin
                end
            endcase
        end
        if (fin) begin
            if (int'(sent_len) > int'(cfg_max_len) + 3) begin
                v.code = ERR_LONG;
            end else if (sent_err != ERR_OK) begin
                v.code = sent_err;
            end else begin
                case (sent_stage) inside
                    PH_BODY, PH_NOSTAR: v.code = cfg_strict ? ERR_NOSUM : ERR_OK;
                    PH_HIGH:            v.code = ERR_HIGH;
                    PH_LOW:             v.code = ERR_LOW;
                    PH_TAIL:            v.code = (sent_cr && cfg_strict) ? ERR_ENDING : ERR_OK;
                    PH_TAIL_BAD:        v.code = cfg_strict ? ERR_ENDING : ERR_OK;
                    default:            v.code = ERR_OK;
                endcase
            end
            v.ok = (v.code == ERR_OK);
            v.xsum = sent_xor;
            if (sentence_plan.size() != 0) begin
                p = sentence_plan.pop_front();
                if (p.typed) v = p.want;
            end
            verdicts_due.push_back(v);
            sent_stage = PH_DOLLAR;
            sent_xor = 8'h00;
            sent_hi = 4'h0;
            sent_len = '0;
            sent_err = ERR_OK;
            sent_cr = 1'b0;
        end
    endtask

    task automatic check_verdict(input logic [15:0] w);
        t_tb_verdict want;
        if (verdicts_due.size() == 0) begin
            $error("verdict word %h with no sentence pending", w);
            fails++;
        end else begin
            want = verdicts_due.pop_front();
            if (w[0] !== want.ok) begin
                $error("sentence_ok: expected %0d, got %0d", want.ok, w[0]);
                fails++;
            end
            if (w[3:1] !== want.code) begin
                $error("error_code: expected %0d, got %0d", want.code, w[3:1]);
                fails++;
            end
            if (w[11:4] !== want.xsum) begin
                $error("computed_xor: expected %h, got %h", want.xsum, w[11:4]);
                fails++;
            end
        end
    endtask

    // monitor and watchdog: all handshakes sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_STRICT) cfg_strict = i_cfg_data[0];
                else if (i_cfg_index == REG_MAX_LEN) cfg_max_len = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_char(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_verdict(m_axis_tdata);
            end
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("FAIL nmea_sentence_validator");
                $finish;
            end
        end
    end

    // receiver stall pattern, redrawn each time the pattern position wraps
    always @(posedge i_clk) begin
        m_axis_tready <= rdy_pat[rdy_pos];
        rdy_pos <= rdy_pos + 4'd1;
        if (rdy_pos == 4'd15) begin
            case ($urandom_range(0, 3))
                0: rdy_pat <= 16'hFFFF;
                1: rdy_pat <= 16'($urandom);
                2: rdy_pat <= 16'd1 << $urandom_range(0, 15);
                default: rdy_pat <= rdy_pat;
            endcase
        end
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = (pacing && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_char(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    // wait for every verdict, then past the block's latency
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic strict_on, input int max_len);
        logic [LEN_W-1:0] val;
        drain_results();
        val = LEN_W'($urandom);
        val[0] = strict_on;
        write_reg(REG_STRICT, val);
        write_reg(REG_MAX_LEN, LEN_W'(max_len));
        i_cfg_valid <= 1'b0;
        cur_strict = strict_on;
        cur_max = max_len;
    endtask

    // kind: 0..69 correct checksum, 70..79 broken checksum, 80..89 no star, 90..99 noise
    function automatic void make_sentence(input int body_len, input int kind);
        logic [7:0] c;
        logic [7:0] x;
        logic [4:0] dig;
        int         n;
        x = 8'h00;
        line_buf.delete();
        if (kind >= 90) begin
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        line_buf.push_back(CH_DOLLAR);
        for (int i = 0; i < body_len; i++) begin
            do c = 8'($urandom_range(32, 126)); while (c == CH_STAR);
            x = x ^ c;
            line_buf.push_back(c);
        end
        if (kind >= 80) begin
            if ($urandom_range(0, 1)) begin
                c = $urandom_range(0, 1) ? 8'($urandom_range(1, 31))
                                         : 8'($urandom_range(127, 255));
                line_buf.push_back(c);
                n = $urandom_range(0, 4);
                repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
            end
            return;
        end
        line_buf.push_back(CH_STAR);
        if (kind >= 70) begin
            case ($urandom_range(0, 3))
                0: begin
                end
                1: line_buf.push_back(hex_char(x[7:4]));
                2: begin
                    do begin
                        c = 8'($urandom_range(1, 255));
                        dig = nibble_of(c);
                    end while (dig[4]);
                    line_buf.push_back(c);
                    line_buf.push_back(hex_char(x[3:0]));
                end
                default: begin
                    line_buf.push_back(hex_char(x[7:4]));
                    line_buf.push_back(hex_char(x[3:0] ^ 4'($urandom_range(1, 15))));
                    if ($urandom_range(0, 1)) line_buf.push_back(CH_LF);
                end
            endcase
            return;
        end
        line_buf.push_back(hex_char(x[7:4]));
        line_buf.push_back(hex_char(x[3:0]));
        n = $urandom_range(0, 19);
        if (n <= 7) begin
            line_buf.push_back(CH_CR);
            line_buf.push_back(CH_LF);
        end else if (n <= 12) begin
            line_buf.push_back(CH_LF);
        end else if (n == 16) begin
            line_buf.push_back(CH_CR);
        end else if (n == 17) begin
            line_buf.push_back(CH_CR);
            line_buf.push_back(CH_CR);
        end else if (n == 18) begin
            line_buf.push_back(CH_LF);
            line_buf.push_back(8'($urandom_range(1, 255)));
        end else if (n == 19) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    // mostly short bodies, some close to the length limit
    function automatic int pick_body_len(input int max_len);
        int r;
        int tgt;
        r = $urandom_range(0, 99);
        if (r < 15 && max_len <= 120) begin
            tgt = max_len + 3 - 7 + int'($urandom_range(0, 4)) - 2;
            return (tgt < 0) ? 0 : tgt;
        end
        if (r < 30) return $urandom_range(13, 40);
        return $urandom_range(0, 12);
    endfunction

    initial begin
        t_verdict_plan p;
        string         txt;
        int            items;
        int            lines;
        int            ml;
        logic          st;

        script.push_back(t_sentence_row'{"X", 1'b1, 82, 1'b1, ERR_DOLLAR, 8'h00});
        script.push_back(t_sentence_row'{"$*00", 1'b1, 82, 1'b1, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$A*41\015\012", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$A*", 1'b1, 82, 1'b1, ERR_HIGH, 8'h41});
        script.push_back(t_sentence_row'{"$A*4", 1'b1, 82, 1'b1, ERR_LOW, 8'h41});
        script.push_back(t_sentence_row'{"$A*G1", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$A*4g", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$A*42", 1'b1, 82, 1'b1, ERR_MISMATCH, 8'h41});
        script.push_back(t_sentence_row'{"$AB", 1'b1, 82, 1'b1, ERR_NOSUM, 8'h03});
        script.push_back(t_sentence_row'{"$A\001B*41", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$a*61\015", 1'b1, 82, 1'b1, ERR_ENDING, 8'h61});
        script.push_back(t_sentence_row'{"$a*61\012", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$a*61\012\012", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$a*61\015\015", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$a*61\015\012x", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$~ *5e", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$\377", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"\377$", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$**", 1'b1, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$AB", 1'b0, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$A*4", 1'b0, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$A*41junk", 1'b0, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$A\015*00", 1'b0, 82, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$*00", 1'b0, 1, 1'b0, ERR_OK, 8'h00});
        script.push_back(t_sentence_row'{"$A*41", 1'b0, 1, 1'b1, ERR_LONG, 8'h41});
        script.push_back(t_sentence_row'{"ZZZZZ", 1'b1, 1, 1'b0, ERR_OK, 8'h00});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sentences, first ones under the reset settings
        foreach (script[r]) begin
            if (script[r].strict_on != cur_strict || script[r].max_len != cur_max) begin
                set_mode(script[r].strict_on, script[r].max_len);
            end
            p.typed = script[r].typed;
            p.want.ok = (script[r].code == ERR_OK);
            p.want.code = script[r].code;
            p.want.xsum = script[r].xsum;
            sentence_plan.push_back(p);
            txt = script[r].text;
            line_buf.delete();
            for (int i = 0; i < txt.len(); i++) line_buf.push_back(txt[i]);
            send_line();
        end

        // random sentences over each strictness and several length limits
        p.typed = 1'b0;
        p.want = '0;
        for (int ph = 0; ph < 8; ph++) begin
            st = (ph % 2 == 0);
            case (ph / 2)
                0: ml = 82;
                1: ml = 1;
                2: ml = 1020;
                default: ml = $urandom_range(2, 120);
            endcase
            set_mode(st, ml);
            pacing = ($urandom_range(0, 3) != 0);
            items = 0;
            lines = 0;
            while (items < 70 || lines < 8) begin
                make_sentence(pick_body_len(ml), $urandom_range(0, 99));
                sentence_plan.push_back(p);
                items += line_buf.size();
                lines++;
                send_line();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fails == 0 && verdicts_due.size() == 0) begin
            $display("PASS nmea_sentence_validator");
        end else begin
            $display("FAIL nmea_sentence_validator");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/nsv_pkg.sv
src/nsv_step.sv
src/nsv_out_reg.sv
src/nmea_sentence_validator.sv
src/nsv_checker.sv
tb/sv/tb_nmea_sentence_validator.sv
